[sv/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define PPWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppwm assertion failed");

// Check cons in the cycle after ante.
`define PPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppwm assertion failed");

`endif

[sv/ppwm_pkg.sv]
`timescale 1ns / 1ps
package ppwm_pkg;

    localparam int MAX_CH     = 2;
    localparam int CH_STRIDE  = 15;
    localparam int CH_FIELD_W = 10;
    localparam int PRE_W      = 17;
    localparam int CYC_W      = 16;

    localparam logic [3:0]       CODE_BYPASS = 4'd15;
    localparam logic [PRE_W-1:0] PRE_LIMIT   = 17'd72000;

    localparam logic [PRE_W-1:0] DIV_TABLE [16] = '{
        17'd120,   17'd180,   17'd240,   17'd360,
        17'd480,   17'd0,     17'd0,     17'd0,
        17'd12000, 17'd24000, 17'd36000, 17'd48000,
        17'd72000, 17'd0,     17'd0,     17'd0
    };

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_CTRL   = 2'd0,
        REG_PER0   = 2'd1,
        REG_PER1   = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CFG_BYP_PRESENT    = 1'b0,
        CFG_DIRECT_PRESENT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_opcode     opcode;
        logic [1:0]  reg_index;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        level_ch0;
        logic        level_ch1;
    } t_out_item;

    typedef struct packed {
        t_cfg_idx idx;
        logic     value;
    } t_cfg_write;

    typedef struct packed {
        logic byp_present;
        logic direct_present;
    } t_cfg;

    typedef struct packed {
        logic [3:0] code;
        logic       enable;
        logic       act_level;
        logic       gate;
        logic       bypass;
    } t_chan_ctl;

    function automatic t_chan_ctl ctl_fields(input logic [CH_FIELD_W-1:0] f);
        t_chan_ctl c;
        c.code      = f[3:0];
        c.enable    = f[4];
        c.act_level = f[5];
        c.gate      = f[6];
        c.bypass    = f[9];
        return c;
    endfunction

    function automatic logic [PRE_W-1:0] div_of(input logic [3:0] code,
                                                 input logic byp_present);
        logic [PRE_W-1:0] d;
        if (code == CODE_BYPASS && byp_present) begin
            d = 17'd1;
        end else begin
            d = DIV_TABLE[code];
        end
        return d;
    endfunction

endpackage

[sv/ppwm_chan_if.sv]
`timescale 1ns / 1ps
interface ppwm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/ppwm_in_reg.sv]
`timescale 1ns / 1ps
module ppwm_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ppwm_chan_if.sink           i_in,
    input  logic                i_take,
    output logic                o_valid,
    output ppwm_pkg::t_in_item  o_item
);

    logic               r_valid;
    ppwm_pkg::t_in_item r_item;

    // Take a new item whenever the slot is empty or drains this cycle.
    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
    end

endmodule

[sv/ppwm_chan.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppwm_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_tick,
    input  ppwm_pkg::t_cfg      i_cfg,
    input  ppwm_pkg::t_chan_ctl i_ctl,
    input  logic [31:0]         i_period_wr,
    output logic                o_level
);

    logic [ppwm_pkg::PRE_W-1:0] r_pre, n_pre;
    logic [ppwm_pkg::CYC_W-1:0] r_cyc, n_cyc;
    logic [31:0]                r_act, n_act;
    logic                       r_phase, n_phase;

    logic [ppwm_pkg::PRE_W-1:0] w_div;
    logic [ppwm_pkg::PRE_W-1:0] w_pre_inc;
    logic                       w_direct;
    logic                       w_run;

    assign w_div     = ppwm_pkg::div_of(i_ctl.code, i_cfg.byp_present);
    assign w_direct  = i_cfg.direct_present && i_ctl.bypass;
    assign w_run     = i_ctl.enable && i_ctl.gate && (w_div != '0);
    assign w_pre_inc = r_pre + 17'd1;

    always_comb begin
        n_pre   = r_pre;
        n_cyc   = r_cyc;
        n_act   = r_act;
        n_phase = r_phase;
        if (i_tick) begin
            if (w_direct) begin
                n_phase = ~r_phase;
            end else begin
                n_phase = 1'b0;
                if (!w_run) begin
                    // Stopped: clear counters, follow the written period at once.
                    n_pre = '0;
                    n_cyc = '0;
                    n_act = i_period_wr;
                end else if (w_pre_inc < w_div) begin
                    n_pre = w_pre_inc;
                end else begin
                    n_pre = '0;
                    if (r_cyc >= r_act[31:16]) begin
                        // Period boundary: latch the pending period word.
                        n_cyc = '0;
                        n_act = i_period_wr;
                    end else begin
                        n_cyc = r_cyc + 16'd1;
                    end
                end
            end
        end
    end

    always_comb begin
        if (w_direct) begin
            o_level = n_phase;
        end else if (!w_run) begin
            o_level = ~i_ctl.act_level;
        end else if (n_cyc < n_act[15:0]) begin
            o_level = i_ctl.act_level;
        end else begin
            o_level = ~i_ctl.act_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= '0;
            r_cyc   <= '0;
            r_act   <= '0;
            r_phase <= 1'b0;
        end else if (i_step) begin
            r_pre   <= n_pre;
            r_cyc   <= n_cyc;
            r_act   <= n_act;
            r_phase <= n_phase;
        end
    end

    `PPWM_ASSERT_NOW(a_pre_bound, i_clk, i_rst_n, 1'b1, r_pre < ppwm_pkg::PRE_LIMIT)
    `PPWM_ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !i_step, $stable(r_pre) && $stable(r_cyc))

endmodule

[sv/prescaled_pwm_peripheral_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Two-channel PWM peripheral driven by items: a source-clock tick, a register
// write or a register read. One item is accepted every clock cycle; each goes
// through an input register and then one pass of channel and register-file
// logic into the result register, from which its result is offered on the output.
// Input flow stops only while a finished result is not taken.
// Configuration writes (prescaler bypass present, direct clock output present)
// are always ready and must be issued while the block is idle.
module prescaled_pwm_peripheral_core #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppwm_chan_if.sink   i_in,
    ppwm_chan_if.source o_out,
    ppwm_chan_if.sink   i_cfg
);

    logic                w_item_valid;
    ppwm_pkg::t_in_item  w_item;
    logic                w_adv;
    logic                w_tick;
    logic                w_wr;
    logic [31:0]         w_ctl_next;
    logic [31:0]         w_rd;
    logic [ppwm_pkg::MAX_CH-1:0] w_lvl;

    logic [31:0]         r_ctl;
    logic [31:0]         r_pw [NUM_CHANNELS];
    ppwm_pkg::t_cfg      r_cfg;
    logic                r_out_valid;
    ppwm_pkg::t_out_item r_out;

    ppwm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_adv),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    assign w_adv  = w_item_valid && (!r_out_valid || o_out.ready);
    assign w_tick = w_item.opcode == ppwm_pkg::OP_TICK;
    assign w_wr   = w_item.opcode == ppwm_pkg::OP_WRITE;

    // Levels after an item reflect a control word written by that same item.
    assign w_ctl_next = (w_wr && w_item.reg_index == ppwm_pkg::REG_CTRL) ?
                        w_item.write_data : r_ctl;

    for (genvar c = 0; c < ppwm_pkg::MAX_CH; c++) begin : g_ch
        if (c < NUM_CHANNELS) begin : g_on
            ppwm_chan u_chan (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_step      (w_adv),
                .i_tick      (w_tick),
                .i_cfg       (r_cfg),
                .i_ctl       (ppwm_pkg::ctl_fields(
                                  w_ctl_next[c*ppwm_pkg::CH_STRIDE +: ppwm_pkg::CH_FIELD_W])),
                .i_period_wr (r_pw[c]),
                .o_level     (w_lvl[c])
            );
        end else begin : g_off
            assign w_lvl[c] = 1'b0;
        end
    end

    always_comb begin
        w_rd = '0;
        if (w_item.opcode == ppwm_pkg::OP_READ) begin
            if (w_item.reg_index == ppwm_pkg::REG_CTRL) begin
                w_rd = r_ctl;
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (int'(w_item.reg_index) == int'(ppwm_pkg::REG_PER0) + c) begin
                    w_rd = r_pw[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pw[c] <= '0;
            end
        end else if (w_adv && w_wr) begin
            r_ctl <= w_ctl_next;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (int'(w_item.reg_index) == int'(ppwm_pkg::REG_PER0) + c) begin
                    r_pw[c] <= w_item.write_data;
                end
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byp_present    <= 1'b1;
            r_cfg.direct_present <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.idx)
                ppwm_pkg::CFG_BYP_PRESENT:    r_cfg.byp_present    <= i_cfg.data.value;
                ppwm_pkg::CFG_DIRECT_PRESENT: r_cfg.direct_present <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.read_data <= w_rd;
            r_out.level_ch0 <= w_lvl[0];
            r_out.level_ch1 <= w_lvl[1];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `PPWM_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `PPWM_ASSERT_NOW(a_in_open, i_clk, i_rst_n, !r_out_valid || o_out.ready, i_in.ready)

endmodule
